>>> rtl/core/epsi_pkg.sv
// shared constants, types and the sine table for the eight-phase sine interpolator
package epsi_pkg;

  localparam int unsigned PHASE_STEPS   = 25;
  localparam int unsigned TURN_STEPS    = 200;
  localparam int unsigned QUARTER_STEPS = 50;
  localparam int unsigned SINE_W        = 16;
  localparam int unsigned ANGLE_W       = 8;
  localparam int unsigned INDEX_W       = 10;
  localparam int unsigned CODE_W        = 11;
  localparam int unsigned AMP_W         = 16;
  localparam int unsigned OUT_W         = 20;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // ceil(2^20 / 25), exact quotient for any value below 1024
  localparam logic [15:0] MOD25_MUL = 16'd41944;
  // ceil(2^36 / 255), exact quotient for any value below 2^27
  localparam logic [28:0] DIV255_MUL = 29'd269488145;
  // half of 255 * 4096, the rounding bias
  localparam logic [38:0] ROUND_BIAS = 39'd522240;

  localparam logic [OUT_W-1:0] OUT_POS_LIMIT = 20'd524287;
  localparam logic [OUT_W-1:0] OUT_NEG_LIMIT = 20'd524288;

  typedef logic signed [SINE_W-1:0] sine_t;
  typedef logic [TURN_STEPS-1:0][SINE_W-1:0] sine_table_t;

  // sin(pi*m/100) in q1.15 from a q2.30 taylor series
  function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned m);
    logic [63:0]        ang;
    logic [63:0]        term;
    logic [63:0]        q;
    logic signed [63:0] acc;
    int unsigned        mm;
    mm   = (m > QUARTER_STEPS) ? QUARTER_STEPS : m;
    ang  = (PI_Q30 * 64'(mm) + 64'd50) / 64'd100;
    term = ang;
    acc  = $signed(ang);
    for (int unsigned j = 1; j <= 9; j++) begin
      term = ((term * ang) >> 30) / 64'(2 * j);
      term = ((term * ang) >> 30) / 64'(2 * j + 1);
      if ((j & 1) != 0) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    q = (64'(acc) + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return SINE_W'(q);
  endfunction

  // one full turn in 200 steps, built from the quarter wave
  function automatic sine_table_t build_sine_table();
    sine_table_t    tbl;
    int unsigned    quad;
    int unsigned    rem;
    logic [SINE_W-1:0] v;
    for (int unsigned n = 0; n < TURN_STEPS; n++) begin
      quad = n / QUARTER_STEPS;
      rem  = n % QUARTER_STEPS;
      if (quad == 0 || quad == 2) begin
        v = quarter_sine(rem);
      end else begin
        v = quarter_sine(QUARTER_STEPS - rem);
      end
      tbl[n] = (quad >= 2) ? SINE_W'(-v) : v;
    end
    return tbl;
  endfunction

  localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

>>> rtl/core/eight_phase_sine_interpolator.sv
// eight-phase sine interpolator: blends two adjacent reference phases and scales the result
//
// Each input transaction carries an 11-bit phase code and a 10-bit sample index and yields
// exactly one output transaction: the weighted blend of the sines of two reference phases
// 45 degrees apart, scaled by the amplitude register (unsigned q4.12, reset 1.0), rounded to
// nearest and saturated to signed q5.15. The block is an 11-stage pipeline that accepts one
// transaction per clock unless it is full and stalled; output valid rises once a transaction
// has passed through every stage register. Each stage holds its own valid bit and stages
// with no data fill up while the output is stalled, so tready drops only when every stage
// is occupied and the output is stalled. The amplitude register is written with cfg_we_i
// and should only change while no transaction is in flight.
module eight_phase_sine_interpolator #(
  parameter int unsigned INDEX_COUNT = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: amplitude, unsigned q4.12
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [10:0] phase_code, [20:11] sample_index, [23:21] zero
  input  logic [23:0] s_axis_tdata_i,
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [19:0] mixed_sample (signed), [23:20] zero
  output logic [23:0] m_axis_tdata_o
);
  import epsi_pkg::*;

  localparam int unsigned NSTAGE = 11;

  // sample index wrap: only needed when the table is shorter than the index range
  localparam bit                 MOD_ACTIVE = (INDEX_COUNT < (2 ** INDEX_W));
  localparam logic [19:0]        MOD_MUL    = 20'((2 ** 20 + INDEX_COUNT - 1) / INDEX_COUNT);
  localparam logic [INDEX_W-1:0] IDX_N      = INDEX_W'(INDEX_COUNT);

  // pipeline control
  logic [NSTAGE-1:0] v_q;
  logic [NSTAGE-1:0] ld;

  // stage registers
  logic [INDEX_W-1:0] sidx1_q;
  logic [CODE_W-1:0]  pc1_q, pc2_q, pc3_q, pc4_q;
  logic [29:0]        p1_q;
  logic [INDEX_W-1:0] r2_q, r3_q;
  logic [25:0]        p3_q;
  logic [4:0]         pos4_q;
  logic [ANGLE_W-1:0] na5_q, nb5_q;
  logic [7:0]         w5_q, w6_q;
  sine_t              sa6_q, sb6_q;
  logic signed [23:0] mix7_q;
  logic [38:0]        mag8_q;
  logic               neg8_q, neg9_q, neg10_q;
  logic [26:0]        t9_q;
  logic [OUT_W-1:0]   q10_q;
  logic [OUT_W-1:0]   out11_q;
  logic [AMP_W-1:0]   amp_q;

  // next values
  logic [29:0]        p1_d;
  logic [19:0]        qn_prod;
  logic [INDEX_W-1:0] r2_d;
  logic [25:0]        p3_d;
  logic [5:0]         q25;
  logic [4:0]         pos4_d;
  logic [2:0]         ka, kb;
  logic [8:0]         sum_a, sum_b;
  logic [ANGLE_W-1:0] na5_d, nb5_d;
  logic signed [24:0] pa, pb;
  logic signed [23:0] mix7_d;
  logic [22:0]        absmix;
  logic [38:0]        mag8_d;
  logic [38:0]        biased;
  logic [26:0]        t9_d;
  logic [55:0]        p10;
  logic [OUT_W-1:0]   out11_d;

  // a stage takes new data when it is empty or its content moves on
  always_comb begin
    ld[NSTAGE-1] = ~v_q[NSTAGE-1] | m_axis_tready_i;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      ld[k] = ~v_q[k] | ld[k+1];
    end
  end

  assign s_axis_tready_o = ld[0];
  assign m_axis_tvalid_o = v_q[NSTAGE-1];
  assign m_axis_tdata_o  = {4'b0, out11_q};

  // stage 1: reciprocal product for the index wrap
  assign p1_d = 30'(s_axis_tdata_i[20:11]) * 30'(MOD_MUL);

  // stage 2: index modulo table length
  assign qn_prod = 20'(p1_q[29:20]) * 20'(IDX_N);
  assign r2_d    = MOD_ACTIVE ? (sidx1_q - qn_prod[INDEX_W-1:0]) : sidx1_q;

  // stage 3: reciprocal product for modulo 25
  assign p3_d = 26'(r2_q) * 26'(MOD25_MUL);

  // stage 4: position within one sine period
  assign q25    = p3_q[25:20];
  assign pos4_d = 5'(r3_q - 10'(10'(q25) * 10'd25));

  // stage 5: table steps of both phases, wrapped to one turn
  assign ka    = pc4_q[10:8];
  assign kb    = ka + 3'd1;
  assign sum_a = 9'(pos4_q) * 9'd8 + 9'(ka) * 9'd25;
  assign sum_b = 9'(pos4_q) * 9'd8 + 9'(kb) * 9'd25;
  assign na5_d = (sum_a >= 9'(TURN_STEPS)) ? ANGLE_W'(sum_a - 9'(TURN_STEPS)) : ANGLE_W'(sum_a);
  assign nb5_d = (sum_b >= 9'(TURN_STEPS)) ? ANGLE_W'(sum_b - 9'(TURN_STEPS)) : ANGLE_W'(sum_b);

  // stage 7: weighted blend, (255-w)*sa + w*sb
  assign pa     = $signed({1'b0, 8'd255 - w6_q}) * sa6_q;
  assign pb     = $signed({1'b0, w6_q}) * sb6_q;
  assign mix7_d = 24'(pa + pb);

  // stage 8: magnitude times amplitude
  assign absmix = mix7_q[23] ? 23'(-mix7_q) : 23'(mix7_q);
  assign mag8_d = 39'(absmix) * 39'(amp_q);

  // stage 9: round and drop the 4096 factor
  assign biased = mag8_q + ROUND_BIAS;
  assign t9_d   = biased[38:12];

  // stage 10: divide by 255
  assign p10 = 56'(t9_q) * 56'(DIV255_MUL);

  // stage 11: restore sign and saturate
  always_comb begin
    if (!neg10_q) begin
      out11_d = (q10_q > OUT_POS_LIMIT) ? OUT_POS_LIMIT : q10_q;
    end else if (q10_q > OUT_NEG_LIMIT) begin
      out11_d = OUT_NEG_LIMIT;
    end else begin
      out11_d = OUT_W'(-q10_q);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      amp_q <= 16'd4096;
    end else begin
      if (cfg_we_i) begin
        amp_q <= cfg_wdata_i;
      end
      if (ld[0]) begin
        v_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (ld[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      sidx1_q <= s_axis_tdata_i[20:11];
      pc1_q   <= s_axis_tdata_i[10:0];
      p1_q    <= p1_d;
    end
    if (ld[1]) begin
      r2_q  <= r2_d;
      pc2_q <= pc1_q;
    end
    if (ld[2]) begin
      r3_q  <= r2_q;
      p3_q  <= p3_d;
      pc3_q <= pc2_q;
    end
    if (ld[3]) begin
      pos4_q <= pos4_d;
      pc4_q  <= pc3_q;
    end
    if (ld[4]) begin
      na5_q <= na5_d;
      nb5_q <= nb5_d;
      w5_q  <= pc4_q[7:0];
    end
    if (ld[5]) begin
      sa6_q <= $signed(SINE_TABLE[na5_q]);
      sb6_q <= $signed(SINE_TABLE[nb5_q]);
      w6_q  <= w5_q;
    end
    if (ld[6]) begin
      mix7_q <= mix7_d;
    end
    if (ld[7]) begin
      mag8_q <= mag8_d;
      neg8_q <= mix7_q[23];
    end
    if (ld[8]) begin
      t9_q   <= t9_d;
      neg9_q <= neg8_q;
    end
    if (ld[9]) begin
      q10_q   <= p10[55:36];
      neg10_q <= neg9_q;
    end
    if (ld[10]) begin
      out11_q <= out11_d;
    end
  end

  // full pipeline behind a stalled output must push back on the input
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i && (&v_q)) |-> !s_axis_tready_o)
    else $error("input ready while every stage is full and output stalled");

  // the quotient stays inside q5.15, saturation is never reached
  a_no_saturate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[9] |-> (q10_q < OUT_NEG_LIMIT))
    else $error("scaled magnitude out of output range");

  // the output sign follows the sign carried down the pipeline
  a_sign_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld[10] && v_q[9]) |=> (out11_q[OUT_W-1] == $past(neg10_q) || out11_q == '0))
    else $error("output sign does not match blended sign");

endmodule
